// ===== sv/skf_pkg.sv =====
// shared constants, types and saturation helpers for the scalar kalman filter
package skf_pkg;

  localparam int DW = 32;          // data word width
  localparam int FB = 24;          // fraction bits
  localparam int MW = DW + 2;      // multiplier operand width
  localparam int PW = 2 * MW;      // full product width
  localparam int RW = PW - FB;     // rounded product width
  localparam int KW = FB + 1;      // gain width, 0 .. 1.0
  localparam int CW = 3;           // config index width
  localparam int NW = DW + FB;     // divider dividend width
  localparam int QCW = $clog2(KW + 1);

  localparam logic [KW-1:0] ONE = {1'b1, {FB{1'b0}}};
  localparam logic signed [PW-1:0] HALF = {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  localparam logic signed [RW:0] SMAX_W = {{(RW-DW+2){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [RW:0] SMIN_W = {{(RW-DW+2){1'b1}}, {(DW-1){1'b0}}};

  // reset values of the config registers
  localparam logic signed [DW-1:0] COEF_RST  = DW'(ONE);
  localparam logic [DW-2:0]        QN_RST    = (DW-1)'(168);
  localparam logic [DW-2:0]        RN_RST    = (DW-1)'(167772);
  localparam logic signed [DW-1:0] IEST_RST  = '0;
  localparam logic [DW-2:0]        IVAR_RST  = (DW-1)'(ONE);

  typedef enum logic [CW-1:0] {
    CFG_STATE_COEF    = 3'd0,
    CFG_PROCESS_NOISE = 3'd1,
    CFG_MEASURE_NOISE = 3'd2,
    CFG_INIT_ESTIMATE = 3'd3,
    CFG_INIT_VARIANCE = 3'd4
  } skf_cfg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } skf_div_st_t;

  function automatic logic signed [DW-1:0] sat_s(input logic signed [RW:0] v);
    logic signed [DW-1:0] r;
    if (v > SMAX_W) begin
      r = SMAX_W[DW-1:0];
    end else if (v < SMIN_W) begin
      r = SMIN_W[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DW-2:0] sat_u(input logic signed [RW:0] v);
    logic [DW-2:0] r;
    if (v > SMAX_W) begin
      r = '1;
    end else if (v < 0) begin
      r = '0;
    end else begin
      r = v[DW-2:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/skf_mul.sv =====
// shared signed multiplier with registered product and round-to-nearest output
module skf_mul import skf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [MW-1:0] a_i,
  input  logic signed [MW-1:0] b_i,
  output logic signed [RW-1:0] rnd_o
);

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] sum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  // ties go toward plus infinity, slicing gives the floor
  assign sum   = prod_q + HALF;
  assign rnd_o = sum[PW-1:FB];

endmodule

// ===== sv/skf_div.sv =====
// restoring serial divider, one quotient bit per cycle
module skf_div import skf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NW-1:0]     dvd_i,
  input  logic [DW-1:0]     dsr_i,
  output logic [KW-1:0]     quo_o,
  output skf_div_st_t       st_o
);

  logic [DW-1:0]  rem_q, rem_d;
  logic [KW-1:0]  dvd_q, dvd_d;
  logic [KW-1:0]  quo_q, quo_d;
  logic [DW-1:0]  dsr_q;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [DW:0]    trial;
  logic           fit;

  assign trial = {rem_q, dvd_q[KW-1]};
  assign fit   = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // quotient fits in KW bits, so the upper dividend bits stay below the divisor
      rem_d  = DW'(dvd_i[NW-1:KW]);
      dvd_d  = dvd_i[KW-1:0];
      quo_d  = '0;
      cnt_d  = QCW'(KW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fit ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
      dvd_d = {dvd_q[KW-2:0], 1'b0};
      quo_d = {quo_q[KW-2:0], fit};
      cnt_d = cnt_q - QCW'(1);
      if (cnt_q == QCW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    if (start_i) begin
      dsr_q <= dsr_i;
    end
  end

  assign quo_o     = quo_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

// ===== sv/scalar_kalman_filter_unit.sv =====
// scalar kalman filter top level: config registers, sequencer and datapath
// per beat: A*x, A*P, t*A plus Q as P-, the 25-step serial gain divider, K times the
// innovation and (1 - K)*P-, then the output register; a new beat is taken only when idle
//   (a zero gain denominator skips the divider)
// the shared multiplier is used five times per beat, one product per cycle
// reset: async active low, config registers to defaults, estimate 0, variance 1.0
module scalar_kalman_filter_unit import skf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  // config write port
  input  logic          cfg_we_i,
  input  logic [CW-1:0] cfg_idx_i,
  input  logic [DW-1:0] cfg_wdata_i,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // [31:0] measurement
  input  logic [0:0]    s_axis_tuser,   // [0] restart
  // output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [87:0]   m_axis_tdata    // [24:0] gain, [56:25] estimate, [87:57] variance
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_AX   = 12'b0000_0000_0010,
    ST_AP   = 12'b0000_0000_0100,
    ST_T    = 12'b0000_0000_1000,
    ST_TA   = 12'b0000_0001_0000,
    ST_PM   = 12'b0000_0010_0000,
    ST_DIV  = 12'b0000_0100_0000,
    ST_DIVW = 12'b0000_1000_0000,
    ST_KD   = 12'b0001_0000_0000,
    ST_NP   = 12'b0010_0000_0000,
    ST_VP   = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } skf_state_e;

  skf_state_e state_q, state_d;

  // config registers
  logic signed [DW-1:0] coef_q;
  logic [DW-2:0]        qn_q;
  logic [DW-2:0]        rn_q;
  logic signed [DW-1:0] iest_q;
  logic [DW-2:0]        ivar_q;

  // filter state
  logic signed [DW-1:0] x_q;
  logic [DW-2:0]        p_q;

  // per-beat working registers
  logic signed [DW-1:0] z_q;
  logic signed [DW-1:0] xm_q;
  logic signed [DW-1:0] t_q;
  logic signed [DW:0]   diff_q;
  logic [DW-2:0]        pm_q;
  logic [KW-1:0]        k_q;
  logic signed [DW-1:0] xn_q;
  logic [DW-2:0]        pn_q;

  // output register
  logic                 ovld_q;
  logic [87:0]          odata_q;

  // shared multiplier
  logic                 mul_en;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [RW-1:0] mul_rnd;

  // divider
  logic                 div_start;
  logic [DW-1:0]        den;
  logic [NW-1:0]        dvd;
  logic [KW-1:0]        quo;
  skf_div_st_t          div_st;

  logic                 in_acc;
  logic                 out_load;
  logic [KW-1:0]        one_mk;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_DONE) && (!ovld_q || m_axis_tready);
  assign one_mk   = ONE - k_q;

  // gain denominator and rounded dividend, pm*2^F + floor(den/2)
  assign den = DW'(pm_q) + DW'(rn_q);
  assign dvd = {pm_q, {FB{1'b0}}} + NW'(den[DW-1:1]);

  skf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .rnd_o (mul_rnd)
  );

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (dvd),
    .dsr_i   (den),
    .quo_o   (quo),
    .st_o    (div_st)
  );

  // config writes, index beyond the list is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RST;
      qn_q   <= QN_RST;
      rn_q   <= RN_RST;
      iest_q <= IEST_RST;
      ivar_q <= IVAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STATE_COEF:    coef_q <= cfg_wdata_i;
        CFG_PROCESS_NOISE: qn_q   <= cfg_wdata_i[DW-2:0];
        CFG_MEASURE_NOISE: rn_q   <= cfg_wdata_i[DW-2:0];
        CFG_INIT_ESTIMATE: iest_q <= cfg_wdata_i;
        CFG_INIT_VARIANCE: ivar_q <= cfg_wdata_i[DW-2:0];
        default: ;
      endcase
    end
  end

  // sequencer: operand select for the shared multiplier and next state
  always_comb begin
    state_d   = state_q;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_AX;
      end
      ST_AX: begin
        // predicted estimate A*x
        mul_en  = 1'b1;
        mul_a   = MW'(coef_q);
        mul_b   = MW'(x_q);
        state_d = ST_AP;
      end
      ST_AP: begin
        // first half of predicted variance, A*P
        mul_en  = 1'b1;
        mul_a   = MW'(coef_q);
        mul_b   = $signed(MW'(p_q));
        state_d = ST_T;
      end
      ST_T: begin
        state_d = ST_TA;
      end
      ST_TA: begin
        // second half, t*A
        mul_en  = 1'b1;
        mul_a   = MW'(t_q);
        mul_b   = MW'(coef_q);
        state_d = ST_PM;
      end
      ST_PM: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // zero denominator gives zero gain without dividing
        if (den == '0) begin
          state_d = ST_KD;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_st.done) state_d = ST_KD;
      end
      ST_KD: begin
        // innovation scaled by the gain
        mul_en  = 1'b1;
        mul_a   = $signed(MW'(k_q));
        mul_b   = MW'(diff_q);
        state_d = ST_NP;
      end
      ST_NP: begin
        // variance shrink (1 - K)*P-
        mul_en  = 1'b1;
        mul_a   = $signed(MW'(one_mk));
        mul_b   = $signed(MW'(pm_q));
        state_d = ST_VP;
      end
      ST_VP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold here while the previous result still waits downstream
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
      x_q     <= IEST_RST;
      p_q     <= IVAR_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
      if (in_acc && s_axis_tuser[0]) begin
        // restart reloads the state before this beat is worked on
        x_q <= iest_q;
        p_q <= ivar_q;
      end else if (out_load) begin
        x_q <= xn_q;
        p_q <= pn_q;
      end
    end
  end

  // datapath registers, written in the sequencer steps that produce them
  always_ff @(posedge clk_i) begin
    if (in_acc) z_q <= s_axis_tdata[DW-1:0];
    if (state_q == ST_AP) xm_q <= sat_s((RW+1)'(mul_rnd));
    if (state_q == ST_T) begin
      t_q    <= sat_s((RW+1)'(mul_rnd));
      diff_q <= (DW+1)'(z_q) - (DW+1)'(xm_q);
    end
    if (state_q == ST_PM) pm_q <= sat_u((RW+1)'(mul_rnd) + $signed((RW+1)'(qn_q)));
    if (state_q == ST_DIV && den == '0) k_q <= '0;
    if (state_q == ST_DIVW && div_st.done) k_q <= (quo > ONE) ? ONE : quo;
    if (state_q == ST_NP) xn_q <= sat_s((RW+1)'(xm_q) + (RW+1)'(mul_rnd));
    if (state_q == ST_VP) pn_q <= sat_u((RW+1)'(mul_rnd));
    if (out_load) odata_q <= {pn_q, xn_q, k_q};
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  // gain never exceeds 1.0 on an output beat
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[KW-1:0] <= ONE))
    else $error("gain above 1.0");

  // corrected variance never exceeds the predicted variance
  a_var_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (pn_q <= pm_q))
    else $error("variance grew at correction");

  // divider only runs while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == ST_DIVW))
    else $error("divider busy outside its wait step");

  // a new beat is only taken after the divider has finished
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_AX && !div_st.busy))
    else $error("accept while busy");

endmodule
